>>> design/console_line_editor_top_macros.svh
// Assertion helpers for the console line editor.
// Both expect clk and rst_n in the enclosing module.
`ifndef CONSOLE_LINE_EDITOR_TOP_MACROS_SVH
`define CONSOLE_LINE_EDITOR_TOP_MACROS_SVH

// same-cycle implication
`define CLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cle_pkg.sv
package cle_pkg;

  localparam int CLE_LINE_LIMIT = 64;
  localparam int IDX_W  = 6;
  localparam int CHAR_W = 8;
  localparam int GEO_W  = 8;
  localparam int POS_W  = 16;
  localparam int QUOT_W = 8;

  localparam logic [GEO_W-1:0] RESET_COLUMNS = 8'd80;
  localparam logic [GEO_W-1:0] RESET_ROWS    = 8'd25;

  // register indexes
  localparam logic [7:0] REG_SCREEN_COLUMNS = 8'd0;
  localparam logic [7:0] REG_SCREEN_ROWS    = 8'd1;
  localparam logic [7:0] REG_START_COLUMN   = 8'd2;
  localparam logic [7:0] REG_START_ROW      = 8'd3;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_LEFT  = 4'd1;
  localparam op_t OP_RIGHT = 4'd2;
  localparam op_t OP_DEL   = 4'd3;
  localparam op_t OP_END   = 4'd4;
  localparam op_t OP_HOME  = 4'd5;
  localparam op_t OP_ENTER = 4'd6;
  localparam op_t OP_BS    = 4'd7;
  localparam op_t OP_PUT   = 4'd8;

  localparam logic [7:0] SC_LEFT  = 8'h4b;
  localparam logic [7:0] SC_RIGHT = 8'h4d;
  localparam logic [7:0] SC_DEL   = 8'h53;
  localparam logic [7:0] SC_END   = 8'h4f;
  localparam logic [7:0] SC_HOME  = 8'h47;
  localparam logic [7:0] SC_F10   = 8'h44;
  localparam logic [7:0] SC_UP    = 8'h48;
  localparam logic [7:0] SC_DOWN  = 8'h50;
  localparam logic [7:0] SC_PGUP  = 8'h49;
  localparam logic [7:0] SC_PGDN  = 8'h51;
  localparam logic [7:0] SC_ESC   = 8'h01;

  localparam logic [7:0] CH_ENTER = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [GEO_W-1:0]  rem;
  } div_res_t;

  function automatic op_t cle_decode(logic [7:0] sc, logic [7:0] ch, logic ctrl);
    op_t op;
    case (sc)
      SC_LEFT:  op = OP_LEFT;
      SC_RIGHT: op = OP_RIGHT;
      SC_DEL:   op = OP_DEL;
      SC_END:   op = OP_END;
      SC_HOME:  op = OP_HOME;
      SC_F10, SC_UP, SC_DOWN, SC_PGUP, SC_PGDN, SC_ESC: op = OP_NONE;
      default: begin
        if (ch == CH_ENTER)                         op = OP_ENTER;
        else if (ch == CH_BS)                       op = OP_BS;
        else if (ctrl && (ch == CH_P || ch == CH_N)) op = OP_NONE;
        else if (ctrl && ch == CH_B)                op = OP_LEFT;
        else if (ctrl && ch == CH_F)                op = OP_RIGHT;
        else if (ch inside {[PRINT_LO:PRINT_HI]})   op = OP_PUT;
        else                                        op = OP_NONE;
      end
    endcase
    return op;
  endfunction

endpackage

>>> design/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cle_div.sv
module cle_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [cle_pkg::POS_W-1:0] dividend,
  input  logic [cle_pkg::GEO_W-1:0] divisor,
  output cle_pkg::div_res_t       res
);

  import cle_pkg::*;

  logic [3:0]        cnt_r;
  logic              done_r;
  logic [POS_W-1:0]  rem_r;
  logic [POS_W-1:0]  den_r;
  logic [QUOT_W-1:0] quot_r;
  logic              ge;

  assign ge = (rem_r >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 4'(QUOT_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 4'd1;
        done_r <= (cnt_r == 4'd1);
      end
    end
  end

  // restoring division, one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      den_r  <= POS_W'(divisor) << (QUOT_W - 1);
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      quot_r <= {quot_r[QUOT_W-2:0], ge};
      den_r  <= den_r >> 1;
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r[GEO_W-1:0];

endmodule

>>> design/console_line_editor_top.sv
// Console line editor: one keystroke per input item, one status result per key, and on
// enter first one result per line character (kind 1), then the status. Keys are taken one
// at a time. A cursor key or ignored key spends most of its time in the eight-step shared
// divider that turns the linear screen position into column and row. Insert, backspace and
// delete first shift the tail of the line through the line store, which has one write port
// and one read port; enter emits the line characters before the status. Output stalls hold
// back the results. The line store needs no clearing after reset.
`include "console_line_editor_top_macros.svh"
module console_line_editor_top #(
  parameter int LINE_LIMIT = cle_pkg::CLE_LINE_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] scan_code, [15:8] char_code
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // in_tuser: [0] ctrl_held
  input  logic        in_tuser,
  // out_tdata: [7:0] line_char, [13:8] edit_index, [19:14] line_length,
  //            [27:20] screen_column, [35:28] screen_row, [39:36] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // out_tuser: [0] kind
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  import cle_pkg::*;

  localparam int DEPTH = LINE_LIMIT - 1;
  localparam int CW    = $clog2(LINE_LIMIT);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(LINE_LIMIT - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLAMP = 4'd1;
  localparam logic [3:0] S_OP    = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_DEL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_STAT  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [CW-1:0]     e_r, e_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  last_cell_r, last_cell_nxt;
  logic [GEO_W-1:0]  cols_r, cols_nxt;
  logic [GEO_W-1:0]  rows_r, rows_nxt;
  logic [GEO_W-1:0]  scol_r, scol_nxt;
  logic [GEO_W-1:0]  srow_r, srow_nxt;
  logic [GEO_W-1:0]  cur_col_r, cur_col_nxt;
  logic [GEO_W-1:0]  cur_row_r, cur_row_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              o_kind_r, o_kind_nxt;
  logic [CHAR_W-1:0] o_char_r, o_char_nxt;
  logic [IDX_W-1:0]  o_idx_r, o_idx_nxt;
  logic [IDX_W-1:0]  o_len_r, o_len_nxt;
  logic [GEO_W-1:0]  o_col_r, o_col_nxt;
  logic [GEO_W-1:0]  o_row_r, o_row_nxt;
  logic              o_last_r, o_last_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              div_start;
  div_res_t          div_res;

  logic [GEO_W-1:0]  cols_eff, rows_eff;
  logic [GEO_W-1:0]  r_src, c_src, r_cl, c_cl, mul_a;
  logic [POS_W-1:0]  mul_p;
  logic              reload;

  logic [POS_W-1:0]  step_amt, back_pos, fwd_pos;
  logic [POS_W:0]    fwd_sum;
  logic [CW-1:0]     ptr_dec;
  logic [CW:0]       ptr_inc;
  logic              out_free;
  logic              advance;

  cle_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH), .AW(AW)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cle_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_r),
    .divisor  (cols_eff),
    .res      (div_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'b0, o_row_r, o_col_r, o_len_r, o_idx_r, o_char_r};

  assign out_free = !out_valid_r || out_tready;

  // geometry, reload position and last cell share one multiplier
  always_comb begin
    cols_eff = (cols_r == '0) ? 8'd1 : cols_r;
    rows_eff = (rows_r == '0) ? 8'd1 : rows_r;
    reload   = cfg_valid && (cfg_index == REG_START_COLUMN || cfg_index == REG_START_ROW);
    r_src    = (cfg_index == REG_START_ROW) ? cfg_data : srow_r;
    c_src    = (cfg_index == REG_START_COLUMN) ? cfg_data : scol_r;
    r_cl     = (r_src > rows_eff - 8'd1) ? rows_eff - 8'd1 : r_src;
    c_cl     = (c_src > cols_eff - 8'd1) ? cols_eff - 8'd1 : c_src;
    mul_a    = reload ? r_cl : rows_eff;
    mul_p    = {8'b0, mul_a} * {8'b0, cols_eff};
  end

  always_comb begin
    case (op_r)
      OP_END:  step_amt = POS_W'(n_r - e_r);
      OP_HOME: step_amt = POS_W'(e_r);
      default: step_amt = 16'd1;
    endcase
    back_pos = (pos_r >= step_amt) ? pos_r - step_amt : '0;
    fwd_sum  = {1'b0, pos_r} + {1'b0, step_amt};
    fwd_pos  = (fwd_sum > {1'b0, last_cell_r}) ? last_cell_r : fwd_sum[POS_W-1:0];
    ptr_dec  = ptr_r - 1'b1;
    ptr_inc  = {1'b0, ptr_r} + 1'b1;
    advance  = ({1'b0, div_res.quot} + 9'd1) < {1'b0, rows_eff};
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    e_nxt         = e_r;
    n_nxt         = n_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    pos_nxt       = pos_r;
    last_cell_nxt = reload ? last_cell_r : mul_p - 16'd1;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    scol_nxt      = scol_r;
    srow_nxt      = srow_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_kind_nxt    = o_kind_r;
    o_char_nxt    = o_char_r;
    o_idx_nxt     = o_idx_r;
    o_len_nxt     = o_len_r;
    o_col_nxt     = o_col_r;
    o_row_nxt     = o_row_r;
    o_last_nxt    = o_last_r;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = cle_decode(in_tdata[7:0], in_tdata[15:8], in_tuser);
          ch_nxt    = in_tdata[15:8];
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (pos_r > last_cell_r) begin
          pos_nxt = last_cell_r;
        end
        state_nxt = S_OP;
      end
      S_OP: begin
        state_nxt = S_DIV;
        case (op_r)
          OP_LEFT: begin
            if (e_r != '0) begin
              e_nxt   = e_r - 1'b1;
              pos_nxt = back_pos;
            end
          end
          OP_RIGHT: begin
            if (e_r < n_r) begin
              e_nxt   = e_r + 1'b1;
              pos_nxt = fwd_pos;
            end
          end
          OP_BS: begin
            if (e_r != '0) begin
              e_nxt     = e_r - 1'b1;
              pos_nxt   = back_pos;
              ptr_nxt   = e_r - 1'b1;
              state_nxt = S_DEL;
            end
          end
          OP_DEL: begin
            if (e_r < n_r) begin
              ptr_nxt   = e_r;
              state_nxt = S_DEL;
            end
          end
          OP_END: begin
            pos_nxt = fwd_pos;
            e_nxt   = n_r;
          end
          OP_HOME: begin
            pos_nxt = back_pos;
            e_nxt   = '0;
          end
          OP_PUT: begin
            if (n_r < FULL) begin
              pos_nxt   = fwd_pos;
              ptr_nxt   = n_r;
              state_nxt = S_INS;
            end
          end
          default: begin
          end
        endcase
      end
      // shift the tail up one slot, read one ahead of the write
      S_INS: begin
        if (pend_r) begin
          ram_we   = 1'b1;
          pend_nxt = 1'b0;
        end
        if (ptr_r > e_r) begin
          ram_raddr     = ptr_dec[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt       = ptr_dec;
        end else if (!pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = e_r[AW-1:0];
          ram_wdata = ch_r;
          n_nxt     = n_r + 1'b1;
          e_nxt     = e_r + 1'b1;
          state_nxt = S_DIV;
        end
      end
      // shift the tail down one slot
      S_DEL: begin
        if (pend_r) begin
          ram_we   = 1'b1;
          pend_nxt = 1'b0;
        end
        if (ptr_inc < {1'b0, n_r}) begin
          ram_raddr     = ptr_inc[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt       = ptr_inc[CW-1:0];
        end else if (!pend_r) begin
          n_nxt     = n_r - 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_res.done) begin
          if (op_r == OP_ENTER) begin
            pos_nxt     = pos_r - POS_W'(div_res.rem) + (advance ? POS_W'(cols_eff) : '0);
            cur_col_nxt = '0;
            cur_row_nxt = advance ? div_res.quot + 8'd1 : div_res.quot;
            if (n_r != '0) begin
              ptr_nxt   = '0;
              ram_raddr = '0;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_STAT;
            end
          end else begin
            cur_col_nxt = div_res.rem;
            cur_row_nxt = div_res.quot;
            state_nxt   = S_STAT;
          end
        end
      end
      S_EMIT: begin
        ram_raddr = ptr_r[AW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = 1'b1;
          o_char_nxt    = ram_rdata;
          o_idx_nxt     = IDX_W'(ptr_r);
          o_len_nxt     = IDX_W'(n_r);
          o_col_nxt     = cur_col_r;
          o_row_nxt     = cur_row_r;
          o_last_nxt    = 1'b0;
          if (ptr_inc == {1'b0, n_r}) begin
            n_nxt     = '0;
            e_nxt     = '0;
            state_nxt = S_STAT;
          end else begin
            ram_raddr = ptr_inc[AW-1:0];
            ptr_nxt   = ptr_inc[CW-1:0];
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = 1'b0;
          o_char_nxt    = '0;
          o_idx_nxt     = IDX_W'(e_r);
          o_len_nxt     = IDX_W'(n_r);
          o_col_nxt     = cur_col_r;
          o_row_nxt     = cur_row_r;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_COLUMNS: cols_nxt = cfg_data;
        REG_SCREEN_ROWS:    rows_nxt = cfg_data;
        REG_START_COLUMN: begin
          scol_nxt = cfg_data;
          pos_nxt  = mul_p + POS_W'(c_cl);
        end
        REG_START_ROW: begin
          srow_nxt = cfg_data;
          pos_nxt  = mul_p + POS_W'(c_cl);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      e_r         <= '0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      last_cell_r <= POS_W'(RESET_COLUMNS * RESET_ROWS - 1);
      cols_r      <= RESET_COLUMNS;
      rows_r      <= RESET_ROWS;
      scol_r      <= '0;
      srow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      e_r         <= e_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      last_cell_r <= last_cell_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      scol_r      <= scol_nxt;
      srow_r      <= srow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ch_r        <= ch_nxt;
    ptr_r       <= ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    cur_col_r   <= cur_col_nxt;
    cur_row_r   <= cur_row_nxt;
    o_kind_r    <= o_kind_nxt;
    o_char_r    <= o_char_nxt;
    o_idx_r     <= o_idx_nxt;
    o_len_r     <= o_len_nxt;
    o_col_r     <= o_col_nxt;
    o_row_r     <= o_row_nxt;
    o_last_r    <= o_last_nxt;
  end

  `CLE_ASSERT_IMP(a_edit_in_line, 1'b1, e_r <= n_r, "edit index beyond line length")
  `CLE_ASSERT_IMP(a_kind_last, out_valid_r, o_kind_r != o_last_r, "kind and last disagree")
  `CLE_ASSERT_IMP(a_char_idx, out_valid_r && o_kind_r, o_idx_r < o_len_r, "char index out of line")
  `CLE_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `CLE_ASSERT_IMP(a_div_done_wait, div_res.done, state_r == S_DWAIT, "divider done unexpected")

endmodule

>>> test/tb_console_line_editor_top.sv
module tb_console_line_editor_top;
  import cle_pkg::*;

  localparam int MAX_CHARS   = CLE_LINE_LIMIT - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 100;

  // indexes past the register list, ignored by the block
  localparam logic [7:0] REG_UNUSED_TOP = 8'hff;
  localparam logic [7:0] REG_UNUSED_MID = 8'h80;

  localparam logic [4:0][7:0] EDIT_SCANS = {SC_HOME, SC_END, SC_DEL, SC_RIGHT, SC_LEFT};
  localparam logic [5:0][7:0] IDLE_SCANS = {SC_ESC, SC_PGDN, SC_PGUP, SC_DOWN, SC_UP, SC_F10};
  localparam logic [3:0][7:0] CTRL_CHARS = {CH_N, CH_P, CH_F, CH_B};

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic [5:0] idx;
    logic [5:0] len;
    logic [7:0] col;
    logic [7:0] row;
    logic       last;
  } line_result_t;

  typedef struct packed {
    logic [7:0] scan;
    logic [7:0] ch;
    logic       ctrl;
    logic       typed;
    logic [5:0] idx;
    logic [5:0] len;
    logic [7:0] col;
    logic [7:0] row;
  } key_row_t;

  // screen 80x25, cursor at 0; typed rows give the status item after the key
  localparam key_row_t DIRECTED [25] = '{
    '{SC_LEFT,  8'h00,    1'b0, 1'b1, 6'd0, 6'd0, 8'd0, 8'd0},
    '{8'h00,    CH_BS,    1'b0, 1'b1, 6'd0, 6'd0, 8'd0, 8'd0},
    '{SC_DEL,   8'h00,    1'b0, 1'b1, 6'd0, 6'd0, 8'd0, 8'd0},
    '{SC_HOME,  8'hff,    1'b1, 1'b1, 6'd0, 6'd0, 8'd0, 8'd0},
    '{8'h00,    CH_B,     1'b1, 1'b1, 6'd0, 6'd0, 8'd0, 8'd0},
    '{SC_END,   8'h00,    1'b0, 1'b1, 6'd0, 6'd0, 8'd0, 8'd0},
    '{8'h00,    PRINT_LO, 1'b0, 1'b1, 6'd1, 6'd1, 8'd1, 8'd0},
    '{8'h00,    PRINT_HI, 1'b1, 1'b1, 6'd2, 6'd2, 8'd2, 8'd0},
    '{SC_LEFT,  8'h41,    1'b0, 1'b1, 6'd1, 6'd2, 8'd1, 8'd0},
    '{8'h00,    8'h7f,    1'b0, 1'b1, 6'd1, 6'd2, 8'd1, 8'd0},
    '{8'h00,    8'h1f,    1'b1, 1'b1, 6'd1, 6'd2, 8'd1, 8'd0},
    '{8'h00,    CH_P,     1'b1, 1'b1, 6'd1, 6'd2, 8'd1, 8'd0},
    '{8'h00,    CH_N,     1'b1, 1'b1, 6'd1, 6'd2, 8'd1, 8'd0},
    '{8'h00,    CH_P,     1'b0, 1'b0, 6'd0, 6'd0, 8'd0, 8'd0},
    '{8'h00,    CH_F,     1'b1, 1'b1, 6'd3, 6'd3, 8'd3, 8'd0},
    '{SC_RIGHT, 8'h00,    1'b0, 1'b1, 6'd3, 6'd3, 8'd3, 8'd0},
    '{SC_HOME,  8'h00,    1'b0, 1'b1, 6'd0, 6'd3, 8'd0, 8'd0},
    '{SC_DEL,   8'h00,    1'b0, 1'b1, 6'd0, 6'd2, 8'd0, 8'd0},
    '{SC_END,   8'h00,    1'b0, 1'b1, 6'd2, 6'd2, 8'd2, 8'd0},
    '{8'h00,    CH_BS,    1'b0, 1'b1, 6'd1, 6'd1, 8'd1, 8'd0},
    '{8'hff,    8'hff,    1'b1, 1'b1, 6'd1, 6'd1, 8'd1, 8'd0},
    '{SC_ESC,   CH_ENTER, 1'b0, 1'b1, 6'd1, 6'd1, 8'd1, 8'd0},
    '{SC_UP,    8'h41,    1'b0, 1'b1, 6'd1, 6'd1, 8'd1, 8'd0},
    '{8'h00,    CH_ENTER, 1'b0, 1'b1, 6'd0, 6'd0, 8'd0, 8'd1},
    '{8'h00,    CH_ENTER, 1'b1, 1'b1, 6'd0, 6'd0, 8'd0, 8'd2}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  console_line_editor_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // editor image kept by the testbench
  logic [7:0]  line_chars [MAX_CHARS];
  logic [5:0]  line_len = '0;
  logic [5:0]  edit_pos = '0;
  int unsigned cursor_pos = 0;
  logic [7:0]  geo_cols = RESET_COLUMNS;
  logic [7:0]  geo_rows = RESET_ROWS;
  logic [7:0]  home_col = '0;
  logic [7:0]  home_row = '0;
  line_result_t expected_q [$];

  int cycle_count = 0;
  int mismatches = 0;
  int results_seen = 0;
  int chars_seen = 0;
  int keys_sent = 0;
  int cfg_writes = 0;
  int settings = 1;
  int burst_left = 0;
  int gap_max = 3;
  logic [15:0] stall_pattern = 16'hffff;
  logic long_hold_req = 1'b0;
  int hold_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_cols();
    return (geo_cols == 0) ? 1 : geo_cols;
  endfunction

  function automatic int unsigned eff_rows();
    return (geo_rows == 0) ? 1 : geo_rows;
  endfunction

  function automatic int unsigned back_by(int unsigned p, int unsigned n);
    return (p >= n) ? p - n : 0;
  endfunction

  function automatic int unsigned fwd_by(int unsigned p, int unsigned n);
    int unsigned lim;
    lim = eff_cols() * eff_rows() - 1;
    return (p + n > lim) ? lim : p + n;
  endfunction

  function automatic void reload_cursor();
    int unsigned c, r;
    c = home_col;
    r = home_row;
    if (c > eff_cols() - 1) c = eff_cols() - 1;
    if (r > eff_rows() - 1) r = eff_rows() - 1;
    cursor_pos = r * eff_cols() + c;
  endfunction

  function automatic op_t key_op(logic [7:0] scan, logic [7:0] ch, logic ctrl);
    case (scan)
      SC_LEFT:  return OP_LEFT;
      SC_RIGHT: return OP_RIGHT;
      SC_DEL:   return OP_DEL;
      SC_END:   return OP_END;
      SC_HOME:  return OP_HOME;
      SC_F10, SC_UP, SC_DOWN, SC_PGUP, SC_PGDN, SC_ESC: return OP_NONE;
      default: ;
    endcase
    if (ch == CH_ENTER) return OP_ENTER;
    if (ch == CH_BS) return OP_BS;
    if (ctrl && (ch == CH_P || ch == CH_N)) return OP_NONE;
    if (ctrl && ch == CH_B) return OP_LEFT;
    if (ctrl && ch == CH_F) return OP_RIGHT;
    if (ch < PRINT_LO || ch > PRINT_HI) return OP_NONE;
    return OP_PUT;
  endfunction

  function automatic void drop_char(int unsigned at);
    int unsigned j;
    if (at >= line_len) return;
    for (j = at; j + 1 < line_len; j++) line_chars[j] = line_chars[j + 1];
    line_len--;
  endfunction

  function automatic void push_result(logic kind, logic [7:0] ch, logic [5:0] idx,
                                      logic [5:0] len, logic last);
    line_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.idx  = idx;
    r.len  = len;
    r.col  = 8'(cursor_pos % eff_cols());
    r.row  = 8'(cursor_pos / eff_cols());
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void apply_key(logic [7:0] scan, logic [7:0] ch, logic ctrl);
    int unsigned lim, r, j;
    lim = eff_cols() * eff_rows() - 1;
    if (cursor_pos > lim) cursor_pos = lim;
    case (key_op(scan, ch, ctrl))
      OP_LEFT: if (edit_pos != 0) begin
        edit_pos--;
        cursor_pos = back_by(cursor_pos, 1);
      end
      OP_RIGHT: if (edit_pos < line_len) begin
        edit_pos++;
        cursor_pos = fwd_by(cursor_pos, 1);
      end
      OP_BS: if (edit_pos != 0) begin
        edit_pos--;
        cursor_pos = back_by(cursor_pos, 1);
        drop_char(edit_pos);
      end
      OP_DEL: drop_char(edit_pos);
      OP_END: begin
        cursor_pos = fwd_by(cursor_pos, line_len - edit_pos);
        edit_pos = line_len;
      end
      OP_HOME: begin
        cursor_pos = back_by(cursor_pos, edit_pos);
        edit_pos = 0;
      end
      OP_PUT: if (line_len < MAX_CHARS) begin
        for (j = line_len; j > edit_pos; j--) line_chars[j] = line_chars[j - 1];
        line_chars[edit_pos] = ch;
        line_len++;
        edit_pos++;
        cursor_pos = fwd_by(cursor_pos, 1);
      end
      OP_ENTER: begin
        r = cursor_pos / eff_cols();
        if (r + 1 < eff_rows()) r++;
        cursor_pos = r * eff_cols();
        for (j = 0; j < line_len; j++) push_result(1'b1, line_chars[j], 6'(j), line_len, 1'b0);
        line_len = 0;
        edit_pos = 0;
      end
      default: ;
    endcase
    push_result(1'b0, 8'h00, edit_pos, line_len, 1'b1);
  endfunction

  function automatic logic [7:0] free_scan();
    logic [7:0] s;
    s = 8'($urandom);
    while (s inside {SC_LEFT, SC_RIGHT, SC_DEL, SC_END, SC_HOME,
                     SC_F10, SC_UP, SC_DOWN, SC_PGUP, SC_PGDN, SC_ESC})
      s = 8'($urandom);
    return s;
  endfunction

  task automatic send_key(input logic [7:0] scan, input logic [7:0] ch, input logic ctrl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ch, scan};
    in_tuser  <= ctrl;
    do @(posedge clk); while (!in_tready);
    apply_key(scan, ch, ctrl);
    burst_left--;
    keys_sent++;
  endtask

  task automatic pick_key(output logic [7:0] scan, output logic [7:0] ch, output logic ctrl);
    int roll;
    roll = $urandom_range(0, 99);
    scan = free_scan();
    ch   = 8'($urandom_range(PRINT_LO, PRINT_HI));
    ctrl = 1'($urandom_range(0, 1));
    if (roll < 12) scan = EDIT_SCANS[$urandom_range(0, 4)];
    else if (roll < 18) begin
      ch = CTRL_CHARS[$urandom_range(0, 3)];
      ctrl = 1'b1;
    end else if (roll < 26) ch = CH_BS;
    else if (roll < 30) scan = IDLE_SCANS[$urandom_range(0, 5)];
    else if (roll < 38) begin
      scan = 8'($urandom);
      ch   = 8'($urandom);
    end else if (roll < 48) ch = CH_ENTER;
  endtask

  task automatic random_keys(input int count);
    logic [7:0] scan, ch;
    logic ctrl;
    repeat (count) begin
      pick_key(scan, ch, ctrl);
      send_key(scan, ch, ctrl);
    end
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_SCREEN_COLUMNS: geo_cols = value;
      REG_SCREEN_ROWS:    geo_rows = value;
      REG_START_COLUMN: begin
        home_col = value;
        reload_cursor();
      end
      REG_START_ROW: begin
        home_row = value;
        reload_cursor();
      end
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic open_phase(input logic [15:0] pattern, input int gaps);
    cfg_valid <= 1'b0;
    stall_pattern <= pattern | 16'h0001;
    gap_max = gaps;
    settings++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_bad(input string what, input line_result_t want,
                            input line_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s at cycle %0d: expected kind %0d char %02h idx %0d len %0d col %0d row %0d last %0d; got kind %0d char %02h idx %0d len %0d col %0d row %0d last %0d pad %h",
               what, cycle_count, want.kind, want.ch, want.idx, want.len, want.col, want.row,
               want.last, got.kind, got.ch, got.idx, got.len, got.col, got.row, got.last,
               out_tdata[39:36]);
  endtask

  // output checker
  always @(posedge clk) begin
    line_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[13:8], out_tdata[19:14],
              out_tdata[27:20], out_tdata[35:28], out_tlast};
      results_seen++;
      if (got.kind) chars_seen++;
      if (expected_q.size() == 0) report_bad("Unexpected item", '0, got);
      else begin
        want = expected_q.pop_front();
        if (got != want || out_tdata[39:36] != 4'h0) report_bad("Mismatch", want, got);
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold on request
  always @(posedge clk) begin
    if (long_hold_req && hold_count < LONG_HOLD) begin
      hold_count <= hold_count + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= stall_pattern[cycle_count[3:0]];
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out at cycle %0d with %0d items outstanding", cycle_count,
               expected_q.size());
      $display("console_line_editor_top test failed");
      $finish;
    end
  end

  initial begin
    line_result_t status;
    logic [7:0] scan, ch;
    logic ctrl;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_key(DIRECTED[i].scan, DIRECTED[i].ch, DIRECTED[i].ctrl);
      if (DIRECTED[i].typed) begin
        status = expected_q.pop_back();
        status.idx = DIRECTED[i].idx;
        status.len = DIRECTED[i].len;
        status.col = DIRECTED[i].col;
        status.row = DIRECTED[i].row;
        expected_q.push_back(status);
      end
    end
    drain();

    // single cell screen, no idling on either side
    write_reg(REG_SCREEN_COLUMNS, 8'd1);
    write_reg(REG_SCREEN_ROWS, 8'd1);
    write_reg(REG_START_COLUMN, 8'd0);
    write_reg(REG_START_ROW, 8'd0);
    write_reg(REG_UNUSED_TOP, 8'h55);
    open_phase(16'hffff, 0);
    random_keys(8);
    drain();

    // largest screen, start in the last cell; receiver holds off for a while
    write_reg(REG_SCREEN_COLUMNS, 8'd255);
    write_reg(REG_SCREEN_ROWS, 8'd255);
    write_reg(REG_START_COLUMN, 8'd254);
    write_reg(REG_START_ROW, 8'd254);
    open_phase(16'($urandom), 4);
    long_hold_req <= 1'b1;
    random_keys(8);
    drain();

    // zero geometry acts as one
    write_reg(REG_SCREEN_COLUMNS, 8'd0);
    write_reg(REG_SCREEN_ROWS, 8'd0);
    write_reg(REG_UNUSED_MID, 8'haa);
    open_phase(16'h0f0f, 2);
    random_keys(8);
    drain();

    // start beyond the screen gets clamped
    write_reg(REG_SCREEN_COLUMNS, 8'd7);
    write_reg(REG_SCREEN_ROWS, 8'd3);
    write_reg(REG_START_COLUMN, 8'd200);
    write_reg(REG_START_ROW, 8'd9);
    open_phase(16'($urandom), 6);
    random_keys(8);
    drain();

    // shrink the screen under the cursor without reloading it
    write_reg(REG_SCREEN_COLUMNS, 8'd40);
    write_reg(REG_SCREEN_ROWS, 8'd10);
    write_reg(REG_START_COLUMN, 8'd39);
    write_reg(REG_START_ROW, 8'd9);
    write_reg(REG_SCREEN_COLUMNS, 8'd16);
    open_phase(16'($urandom), 3);
    random_keys(8);
    drain();

    // fill the line past its limit, wrapping across rows, then edit and enter
    write_reg(REG_SCREEN_COLUMNS, 8'd20);
    write_reg(REG_SCREEN_ROWS, 8'd6);
    write_reg(REG_START_COLUMN, 8'd15);
    write_reg(REG_START_ROW, 8'd1);
    open_phase(16'($urandom), 5);
    repeat (MAX_CHARS + 3) begin
      scan = free_scan();
      ch   = 8'($urandom_range(PRINT_LO, PRINT_HI));
      ctrl = 1'($urandom_range(0, 1));
      if (ctrl && ch inside {CH_B, CH_F, CH_P, CH_N}) ctrl = 1'b0;
      send_key(scan, ch, ctrl);
    end
    random_keys(8);
    send_key(free_scan(), CH_ENTER, 1'($urandom_range(0, 1)));
    drain();

    write_reg(REG_SCREEN_COLUMNS, 8'd80);
    write_reg(REG_SCREEN_ROWS, 8'd25);
    write_reg(REG_START_COLUMN, 8'd5);
    write_reg(REG_START_ROW, 8'd3);
    open_phase(16'($urandom), 8);
    random_keys(12);
    drain();

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d keys across %0d screen settings with %0d register writes",
             keys_sent, settings, cfg_writes);
    $display("Checked %0d output items (%0d line characters), %0d mismatches",
             results_seen, chars_seen, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) $display("console_line_editor_top test passed");
    else $display("console_line_editor_top test failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/cle_pkg.sv
design/cle_ram.sv
design/cle_div.sv
design/console_line_editor_top.sv
test/tb_console_line_editor_top.sv
